// File: rtl/kst_pkg.sv
// Package for the spanning tree engine: sizes, input kind codes, sequencer states.
// No dependencies.
package kst_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int MAX_EDGES    = 256;
	localparam int VX_W   = $clog2(MAX_VERTICES);
	localparam int SZ_W   = VX_W + 1;
	localparam int EA_W   = $clog2(MAX_EDGES);
	localparam int EC_W   = $clog2(MAX_EDGES + 1);
	localparam int NV_W   = 6;
	localparam int COST_W = 32;
	localparam int KEY_W  = COST_W + EA_W;
	localparam int EDGE_W = 2 * VX_W + COST_W;

	localparam logic [1:0] KIND_LOAD     = 2'd0;
	localparam logic [1:0] KIND_LOAD_RUN = 2'd1;
	localparam logic [1:0] KIND_RUN      = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_SCAN,
		ST_PICK,
		ST_FA_RD,
		ST_FA_WT,
		ST_FB_RD,
		ST_FB_WT,
		ST_JOIN,
		ST_GROW,
		ST_SUM
	} state_t;

endpackage

// File: rtl/kruskal_spanning_tree.sv
// Kruskal spanning tree engine: edge store memory, union-find memory, sequencer.
// Depends on kst_pkg.
//
// channel   | handshake                 | payload
// ----------+---------------------------+----------------------------------------------
// command   | start, busy               | kind, from_vertex, to_vertex, edge_cost
// config    | cfg_valid, cfg_ready      | cfg_data (num_vertices)
// result    | result_valid (strobe)     | is_summary .. last
//
// A load stores the edge while the engine stays idle. A run resets every union-find entry,
// then makes one pass over the n stored edges, through the single store read port, for
// each sorted edge plus a final empty pass. Each pass ends in a pick step; an in-range edge
// then gets two root walks and, if its roots differ, join and grow steps. The summary
// transfer follows the last pass through the pick and summary states. Reset clears control
// state; store contents are undefined until loaded. Results are strobed; the receiver cannot stall.
module kruskal_spanning_tree
	import kst_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               kind,
	input  logic [VX_W-1:0]          from_vertex,
	input  logic [VX_W-1:0]          to_vertex,
	input  logic signed [COST_W-1:0] edge_cost,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [NV_W-1:0]          cfg_data,
	output logic                     result_valid,
	output logic                     is_summary,
	output logic [VX_W-1:0]          tree_from,
	output logic [VX_W-1:0]          tree_to,
	output logic signed [COST_W-1:0] tree_cost,
	output logic signed [63:0]       total_cost,
	output logic [VX_W-1:0]          tree_edge_count,
	output logic                     overflow,
	output logic                     last
);

	state_t state_q, state_d;

	logic [NV_W-1:0]   nv_q;
	logic [NV_W-1:0]   nv_eff;
	logic [EC_W-1:0]   count_q;
	logic              ovf_q;

	// edge store
	logic [EDGE_W-1:0] es_mem [MAX_EDGES];
	logic [EDGE_W-1:0] es_rd_q;
	logic              es_we;
	logic [EA_W-1:0]   es_waddr;
	logic [EA_W-1:0]   es_raddr;

	// union-find table: {parent, size}
	logic [VX_W+SZ_W-1:0] uf_mem [MAX_VERTICES];
	logic [VX_W+SZ_W-1:0] uf_rd_q;
	logic                 uf_we;
	logic [VX_W-1:0]      uf_waddr;
	logic [VX_W+SZ_W-1:0] uf_wdata;
	logic [VX_W-1:0]      uf_raddr;
	logic [VX_W-1:0]      uf_par;
	logic [SZ_W-1:0]      uf_sz;

	logic [VX_W-1:0]   clr_q;
	logic [EC_W-1:0]   ridx_q;
	logic              pend_s1;
	logic [EA_W-1:0]   idx_s1;
	logic              have_prev_q;
	logic [KEY_W-1:0]  prev_q;
	logic              best_v_q;
	logic [KEY_W-1:0]  best_q;
	logic [VX_W-1:0]   bfrom_q, bto_q;
	logic [COST_W-1:0] bcost_q;
	logic [KEY_W-1:0]  cand_key;
	logic              cand_ok;
	logic [VX_W-1:0]   va_q, vb_q;
	logic [VX_W-1:0]   ra_q;
	logic [SZ_W-1:0]   sza_q;
	logic [SZ_W-1:0]   szb_q;
	logic [VX_W-1:0]   big, sub_root;
	logic [63:0]       total_q;
	logic [VX_W-1:0]   acc_q;
	logic              take;
	logic              scan_done;
	logic              in_range;

	assign take      = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign nv_eff    = (nv_q > NV_W'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : nv_q;
	assign uf_par    = uf_rd_q[VX_W+SZ_W-1:SZ_W];
	assign uf_sz     = uf_rd_q[SZ_W-1:0];
	assign scan_done = (ridx_q == count_q) && !pend_s1;
	assign in_range  = ({1'b0, bfrom_q} < nv_eff) && ({1'b0, bto_q} < nv_eff);

	// sort key: biased cost then arrival index, so ties keep arrival order
	assign cand_key = {~es_rd_q[COST_W-1], es_rd_q[COST_W-2:0], idx_s1};
	assign cand_ok  = pend_s1 && (!have_prev_q || cand_key > prev_q)
		&& (!best_v_q || cand_key < best_q);

	// larger set keeps the root; ties keep the first endpoint's root
	assign big      = (sza_q < szb_q) ? vb_q : ra_q;
	assign sub_root = (sza_q < szb_q) ? ra_q : vb_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && (kind == KIND_LOAD_RUN || kind == KIND_RUN))
					state_d = ST_CLR;
			end
			ST_CLR: begin
				if (clr_q == '1)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done)
					state_d = ST_PICK;
			end
			ST_PICK: begin
				if (!best_v_q)
					state_d = ST_SUM;
				else if (in_range)
					state_d = ST_FA_RD;
				else
					state_d = ST_SCAN;
			end
			ST_FA_RD: state_d = ST_FA_WT;
			ST_FA_WT: begin
				if (uf_par == va_q)
					state_d = ST_FB_RD;
				else
					state_d = ST_FA_RD;
			end
			ST_FB_RD: state_d = ST_FB_WT;
			ST_FB_WT: begin
				if (uf_par != vb_q)
					state_d = ST_FB_RD;
				else if (vb_q == ra_q)
					state_d = ST_SCAN;
				else
					state_d = ST_JOIN;
			end
			ST_JOIN: state_d = ST_GROW;
			ST_GROW: state_d = ST_SCAN;
			ST_SUM:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		es_we    = (state_q == ST_IDLE) && take
			&& (kind == KIND_LOAD || kind == KIND_LOAD_RUN)
			&& (count_q < EC_W'(MAX_EDGES));
		es_waddr = count_q[EA_W-1:0];
		es_raddr = ridx_q[EA_W-1:0];
		uf_raddr = (state_q == ST_FB_RD) ? vb_q : va_q;
		uf_we    = 1'b0;
		uf_waddr = clr_q;
		uf_wdata = {clr_q, SZ_W'(1)};
		unique case (state_q)
			ST_CLR: uf_we = 1'b1;
			ST_JOIN: begin
				uf_we    = 1'b1;
				uf_waddr = sub_root;
				uf_wdata = {big, SZ_W'(1)};
			end
			ST_GROW: begin
				uf_we    = 1'b1;
				uf_waddr = big;
				uf_wdata = {big, sza_q + szb_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (es_we)
			es_mem[es_waddr] <= {from_vertex, to_vertex, edge_cost};
		es_rd_q <= es_mem[es_raddr];
		if (uf_we)
			uf_mem[uf_waddr] <= uf_wdata;
		uf_rd_q <= uf_mem[uf_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nv_q         <= NV_W'(MAX_VERTICES);
			count_q      <= '0;
			ovf_q        <= 1'b0;
			clr_q        <= '0;
			ridx_q       <= '0;
			pend_s1      <= 1'b0;
			have_prev_q  <= 1'b0;
			best_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready)
				nv_q <= cfg_data;
			if (state_q == ST_IDLE && take && (kind == KIND_LOAD || kind == KIND_LOAD_RUN)
				&& count_q == EC_W'(MAX_EDGES))
				ovf_q <= 1'b1;
			if (es_we)
				count_q <= count_q + 1'b1;
			if (state_q == ST_CLR)
				clr_q <= clr_q + 1'b1;
			// scan read pipeline
			pend_s1 <= (state_q == ST_SCAN) && (ridx_q != count_q);
			if (state_q == ST_SCAN && ridx_q != count_q)
				ridx_q <= ridx_q + 1'b1;
			if (cand_ok)
				best_v_q <= 1'b1;
			// start of a new selection pass
			if (state_d == ST_SCAN && state_q != ST_SCAN) begin
				ridx_q   <= '0;
				best_v_q <= 1'b0;
				if (state_q == ST_CLR) begin
					have_prev_q <= 1'b0;
				end else begin
					have_prev_q <= 1'b1;
				end
			end
			if (state_q == ST_SUM) begin
				count_q      <= '0;
				ovf_q        <= 1'b0;
				result_valid <= 1'b1;
			end
			if (state_q == ST_JOIN)
				result_valid <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= ridx_q[EA_W-1:0];
		if (cand_ok) begin
			best_q  <= cand_key;
			bfrom_q <= es_rd_q[EDGE_W-1:VX_W+COST_W];
			bto_q   <= es_rd_q[VX_W+COST_W-1:COST_W];
			bcost_q <= es_rd_q[COST_W-1:0];
		end
		if (state_d == ST_SCAN && state_q != ST_SCAN)
			prev_q <= best_q;
		if (state_q == ST_CLR) begin
			total_q <= '0;
			acc_q   <= '0;
		end
		if (state_q == ST_PICK) begin
			va_q <= bfrom_q;
			vb_q <= bto_q;
		end
		if (state_q == ST_FA_WT) begin
			if (uf_par == va_q) begin
				ra_q  <= va_q;
				sza_q <= uf_sz;
			end else begin
				va_q <= uf_par;
			end
		end
		if (state_q == ST_FB_WT) begin
			if (uf_par == vb_q)
				szb_q <= uf_sz;
			else
				vb_q <= uf_par;
		end
		if (state_q == ST_JOIN) begin
			total_q         <= total_q + {{(64-COST_W){bcost_q[COST_W-1]}}, bcost_q};
			acc_q           <= acc_q + 1'b1;
			is_summary      <= 1'b0;
			tree_from       <= bfrom_q;
			tree_to         <= bto_q;
			tree_cost       <= bcost_q;
			total_cost      <= '0;
			tree_edge_count <= '0;
			overflow        <= 1'b0;
			last            <= 1'b0;
		end
		if (state_q == ST_SUM) begin
			is_summary      <= 1'b1;
			tree_from       <= '0;
			tree_to         <= '0;
			tree_cost       <= '0;
			total_cost      <= total_q;
			tree_edge_count <= acc_q;
			overflow        <= ovf_q;
			last            <= 1'b1;
		end
	end

endmodule

// File: tb/tb.sv
// Testbench for the Kruskal spanning tree engine: edge loads, runs and the vertex-count register.
// Expected tree and summary transfers come from a behavioral union-find model inside this file.
// Depends on kst_pkg and kruskal_spanning_tree.
`timescale 1ns / 1ps

module tb
	import kst_pkg::*;
();

	typedef struct packed {
		logic                     is_summary;
		logic [VX_W-1:0]          tree_from;
		logic [VX_W-1:0]          tree_to;
		logic signed [COST_W-1:0] tree_cost;
		logic signed [63:0]       total_cost;
		logic [VX_W-1:0]          tree_edge_count;
		logic                     overflow;
		logic                     last;
	} tree_item_t;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 40;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               kind = KIND_LOAD;
	logic [VX_W-1:0]          from_vertex = '0;
	logic [VX_W-1:0]          to_vertex = '0;
	logic signed [COST_W-1:0] edge_cost = '0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [NV_W-1:0]          cfg_data = '0;
	logic                     result_valid;
	logic                     is_summary;
	logic [VX_W-1:0]          tree_from;
	logic [VX_W-1:0]          tree_to;
	logic signed [COST_W-1:0] tree_cost;
	logic signed [63:0]       total_cost;
	logic [VX_W-1:0]          tree_edge_count;
	logic                     overflow;
	logic                     last;

	kruskal_spanning_tree dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.from_vertex(from_vertex), .to_vertex(to_vertex), .edge_cost(edge_cost),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .is_summary(is_summary), .tree_from(tree_from),
		.tree_to(tree_to), .tree_cost(tree_cost), .total_cost(total_cost),
		.tree_edge_count(tree_edge_count), .overflow(overflow), .last(last)
	);

	always #4 clk = ~clk;

	// model state
	logic [NV_W-1:0]          nv_reg = 6'd32;
	logic [VX_W-1:0]          store_from [MAX_EDGES];
	logic [VX_W-1:0]          store_to [MAX_EDGES];
	logic signed [COST_W-1:0] store_cost [MAX_EDGES];
	int                       store_count = 0;
	logic                     store_ovf = 1'b0;
	int                       uf_parent [MAX_VERTICES];
	int                       uf_size [MAX_VERTICES];
	tree_item_t               pending_tree_items [$];
	int                       fail_count = 0;
	int                       burst_left = 0;
	int                       edges_sent = 0;

	function automatic int find_root(int v);
		int r;
		int nx;
		r = v;
		while (uf_parent[r] != r) r = uf_parent[r];
		while (v != r) begin
			nx = uf_parent[v];
			uf_parent[v] = r;
			v = nx;
		end
		return r;
	endfunction

	function automatic void store_edge(logic [VX_W-1:0] a, logic [VX_W-1:0] b,
			logic signed [COST_W-1:0] c);
		if (store_count < MAX_EDGES) begin
			store_from[store_count] = a;
			store_to[store_count] = b;
			store_cost[store_count] = c;
			store_count++;
		end else begin
			store_ovf = 1'b1;
		end
	endfunction

	function automatic void build_tree();
		int order [MAX_EDGES];
		int eff_nv;
		int i;
		int j;
		int e;
		int x;
		int y;
		int t;
		int accepted;
		logic signed [63:0] total;
		tree_item_t it;
		eff_nv = (nv_reg > MAX_VERTICES) ? MAX_VERTICES : int'(nv_reg);
		accepted = 0;
		total = '0;
		// stable insertion sort on signed cost
		for (i = 0; i < store_count; i++) begin
			j = i;
			while (j > 0 && store_cost[order[j-1]] > store_cost[i]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (i = 0; i < MAX_VERTICES; i++) begin
			uf_parent[i] = i;
			uf_size[i] = 1;
		end
		for (i = 0; i < store_count; i++) begin
			e = order[i];
			if (store_from[e] >= eff_nv || store_to[e] >= eff_nv) continue;
			x = find_root(store_from[e]);
			y = find_root(store_to[e]);
			if (x == y) continue;
			if (uf_size[x] < uf_size[y]) begin
				t = x;
				x = y;
				y = t;
			end
			uf_size[x] += uf_size[y];
			uf_parent[y] = x;
			total += 64'(store_cost[e]);
			accepted++;
			if (accepted <= 31) begin
				it = '0;
				it.tree_from = store_from[e];
				it.tree_to = store_to[e];
				it.tree_cost = store_cost[e];
				pending_tree_items = {pending_tree_items, it};
			end
		end
		it = '0;
		it.is_summary = 1'b1;
		it.total_cost = total;
		it.tree_edge_count = accepted[VX_W-1:0];
		it.overflow = store_ovf;
		it.last = 1'b1;
		pending_tree_items = {pending_tree_items, it};
		store_count = 0;
		store_ovf = 1'b0;
	endfunction

	// one command transfer; start stays high inside a burst
	task automatic send_cmd(logic [1:0] k, logic [VX_W-1:0] a, logic [VX_W-1:0] b,
			logic signed [COST_W-1:0] c);
		int gap;
		start <= 1'b1;
		kind <= k;
		from_vertex <= a;
		to_vertex <= b;
		edge_cost <= c;
		do @(posedge clk); while (busy);
		if (k == KIND_LOAD || k == KIND_LOAD_RUN) store_edge(a, b, c);
		if (k == KIND_LOAD_RUN || k == KIND_RUN) build_tree();
		edges_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_tree_items.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_nv(logic [NV_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		nv_reg = v;
	endtask

	function automatic logic signed [COST_W-1:0] rand_cost();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 6)) - 3;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic test_extremes();
		send_cmd(KIND_LOAD, 5'd0, 5'd31, 32'sh7fffffff);
		send_cmd(KIND_LOAD, 5'd31, 5'd0, 32'sh80000000);
		send_cmd(KIND_LOAD, 5'd7, 5'd7, -32'sd5);           // self loop
		send_cmd(KIND_LOAD, 5'd1, 5'd2, 32'sd3);
		send_cmd(KIND_LOAD, 5'd2, 5'd3, 32'sd3);            // equal cost, arrival order
		send_cmd(KIND_LOAD, 5'd1, 5'd3, 32'sd3);
		send_cmd(KIND_NONE, 5'd31, 5'd31, 32'sh7fffffff);   // ignored kind
		send_cmd(KIND_LOAD_RUN, 5'd31, 5'd1, 32'sh80000000);
		send_cmd(KIND_RUN, 5'd0, 5'd0, 32'sd0);             // run on an empty store
		send_cmd(KIND_LOAD_RUN, 5'd4, 5'd5, -32'sd1);
		drain();
	endtask

	task automatic test_vertex_limit();
		logic [NV_W-1:0] nv_list [4] = '{6'd0, 6'd1, 6'd63, 6'd5};
		foreach (nv_list[n]) begin
			write_nv(nv_list[n]);
			send_cmd(KIND_LOAD, 5'd0, 5'd1, 32'sd2);
			send_cmd(KIND_LOAD, 5'd4, 5'd5, 32'sd1);
			send_cmd(KIND_LOAD, 5'd5, 5'd0, 32'sd1);
			send_cmd(KIND_LOAD_RUN, 5'd31, 5'd30, 32'sd0);
		end
		write_nv(6'd32);
	endtask

	task automatic test_random();
		int n;
		while (edges_sent < 120) begin
			if ($urandom_range(0, 3) == 0)
				write_nv($urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(1, 32)));
			n = $urandom_range(0, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_cmd(KIND_NONE, 5'($urandom), 5'($urandom), $signed($urandom));
				else
					send_cmd(KIND_LOAD, 5'($urandom), 5'($urandom), rand_cost());
			end
			if ($urandom_range(0, 1))
				send_cmd(KIND_LOAD_RUN, 5'($urandom), 5'($urandom), rand_cost());
			else
				send_cmd(KIND_RUN, 5'($urandom), 5'($urandom), $signed($urandom));
		end
		drain();
	endtask

	// result checker: strobed transfers cannot be stalled
	always @(posedge clk) begin
		tree_item_t want;
		if (result_valid) begin
			if (pending_tree_items.size() == 0) begin
				$error("unexpected result transfer");
				fail_count++;
			end else begin
				want = pending_tree_items.pop_front();
				if (is_summary !== want.is_summary) begin
					$error("is_summary exp %0d got %0d", want.is_summary, is_summary);
					fail_count++;
				end
				if (tree_from !== want.tree_from) begin
					$error("tree_from exp %0d got %0d", want.tree_from, tree_from);
					fail_count++;
				end
				if (tree_to !== want.tree_to) begin
					$error("tree_to exp %0d got %0d", want.tree_to, tree_to);
					fail_count++;
				end
				if (tree_cost !== want.tree_cost) begin
					$error("tree_cost exp %0d got %0d", want.tree_cost, tree_cost);
					fail_count++;
				end
				if (total_cost !== want.total_cost) begin
					$error("total_cost exp %0d got %0d", want.total_cost, total_cost);
					fail_count++;
				end
				if (tree_edge_count !== want.tree_edge_count) begin
					$error("tree_edge_count exp %0d got %0d", want.tree_edge_count,
						tree_edge_count);
					fail_count++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow exp %0d got %0d", want.overflow, overflow);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last exp %0d got %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_vertex_limit();
		test_random();
		if (fail_count == 0 && pending_tree_items.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("tb: FAIL");
		$finish;
	end

endmodule
